// ===== rtl/core/moving_average_sma_ema_unit_defines.svh =====
// assertion macros shared by the moving average checks
`ifndef MOVING_AVERAGE_SMA_EMA_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_SMA_EMA_UNIT_DEFINES_SVH

// condition now, consequence in the next cycle
`define MASMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("moving average: next-cycle check failed");

// condition and consequence in the same cycle
`define MASMA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("moving average: same-cycle check failed");

`endif

// ===== rtl/core/masma_pkg.sv =====
`default_nettype none

package masma_pkg;

  // storage sizes (window depth must be a power of two)
  localparam int WINDOW_MAX = 64;
  localparam int PRICE_BITS = 32;

  localparam int PTR_BITS  = $clog2(WINDOW_MAX);
  localparam int N_BITS    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS  = PRICE_BITS + PTR_BITS;
  localparam int DIV_BITS  = $clog2(SUM_BITS);

  // register widths fixed by the register map
  localparam int WL_BITS    = 7;
  localparam int ALPHA_BITS = 17;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_BITS  = PRICE_BITS + FRAC_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = ALPHA_BITS;

  localparam logic [WL_BITS-1:0]    WL_RESET    = 7'd10;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 17'd11916;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_EMA_ALPHA     = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_MUL,
    ST_EMA
  } state_e;

  typedef struct packed {
    logic accept;     // latch price, read oldest ring entry
    logic accum;      // update sum, ring and pointers, load divider
    logic div_step;   // one quotient bit
    logic mul;        // register the ema step product
    logic emit_load;  // update ema, load output register
  } cmd_t;

  typedef struct packed {
    logic emit;       // this transaction completes the window
    logic div_last;   // last quotient bit this cycle
    logic out_free;   // output register can take a result
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/masma_ctrl.sv =====
`default_nettype none

module masma_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  masma_pkg::status_t status_i,
  output masma_pkg::cmd_t    cmd_o
);

  masma_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= masma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      masma_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = masma_pkg::ST_ACCUM;
        end
      end
      masma_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.emit ? masma_pkg::ST_DIV : masma_pkg::ST_IDLE;
      end
      masma_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = masma_pkg::ST_MUL;
        end
      end
      masma_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = masma_pkg::ST_EMA;
      end
      masma_pkg::ST_EMA: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = masma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = masma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/masma_dp.sv =====
`default_nettype none

module masma_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  masma_pkg::cmd_t                        cmd_i,
  output masma_pkg::status_t                     status_o,
  input  logic [masma_pkg::PRICE_BITS-1:0]       price_i,
  input  logic                                   cfg_we_i,
  input  logic [masma_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [masma_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [masma_pkg::PRICE_BITS-1:0]       simple_avg_o,
  output logic [masma_pkg::PRICE_BITS-1:0]       exp_avg_o
);

  localparam int PriceBits = masma_pkg::PRICE_BITS;
  localparam int PtrBits   = masma_pkg::PTR_BITS;
  localparam int NBits     = masma_pkg::N_BITS;
  localparam int SumBits   = masma_pkg::SUM_BITS;
  localparam int DivBits   = masma_pkg::DIV_BITS;
  localparam int WlBits    = masma_pkg::WL_BITS;
  localparam int AlphaBits = masma_pkg::ALPHA_BITS;
  localparam int FracBits  = masma_pkg::FRAC_BITS;
  localparam int ProdBits  = masma_pkg::PROD_BITS;
  localparam int WinMax    = masma_pkg::WINDOW_MAX;
  localparam int CmpBits   = (NBits > WlBits) ? NBits : WlBits;

  // configuration
  logic [WlBits-1:0]    wl_q;
  logic [AlphaBits-1:0] alpha_q;
  logic                 restart;

  assign restart = cfg_we_i &&
                   (cfg_idx_i == masma_pkg::CFG_IDX_BITS'(masma_pkg::REG_WINDOW_LENGTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= masma_pkg::WL_RESET;
      alpha_q <= masma_pkg::ALPHA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        masma_pkg::REG_WINDOW_LENGTH: wl_q    <= cfg_data_i[WlBits-1:0];
        masma_pkg::REG_EMA_ALPHA:     alpha_q <= cfg_data_i[AlphaBits-1:0];
        default: ;
      endcase
    end
  end

  // effective window, zero counts as one, lengths above 64 count as 64
  logic [NBits-1:0] win_n;
  always_comb begin
    if (wl_q == '0) begin
      win_n = NBits'(1);
    end else if (CmpBits'(wl_q) > CmpBits'(WinMax)) begin
      win_n = NBits'(WinMax);
    end else begin
      win_n = NBits'(wl_q);
    end
  end

  // ring state
  logic [PtrBits-1:0]   slot_q;
  logic [NBits-1:0]     fill_q;
  logic [SumBits-1:0]   sum_q, sum_d;
  logic [PriceBits-1:0] price_q;
  logic [PriceBits-1:0] ring_rd_q;
  logic [PriceBits-1:0] ring_mem [WinMax];
  logic [PtrBits-1:0]   oldest;
  logic                 full;

  assign oldest = slot_q - PtrBits'(win_n);
  assign full   = (fill_q >= win_n);
  assign sum_d  = sum_q - (full ? SumBits'(ring_rd_q) : '0) + SumBits'(price_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      ring_mem[slot_q] <= price_q;
    end
    if (cmd_i.accept) begin
      ring_rd_q <= ring_mem[oldest];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q <= price_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (restart) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.accum) begin
      slot_q <= slot_q + PtrBits'(1);
      fill_q <= full ? fill_q : fill_q + NBits'(1);
      sum_q  <= sum_d;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [SumBits-1:0] quo_q;
  logic [NBits-1:0]   rem_q;
  logic [DivBits-1:0] div_cnt_q;
  logic [NBits:0]     rem_sh;
  logic [NBits:0]     rem_sub;
  logic               rem_ge;

  assign rem_sh  = {rem_q, quo_q[SumBits-1]};
  assign rem_ge  = (rem_sh >= {1'b0, win_n});
  assign rem_sub = rem_sh - {1'b0, win_n};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      quo_q <= sum_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SumBits-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[NBits-1:0] : rem_sh[NBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.accum) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DivBits'(1);
    end
  end

  // ema step product
  logic [PriceBits-1:0] ema_q;
  logic                 seeded_q;
  logic                 up;
  logic [PriceBits-1:0] mag;
  logic [ProdBits-1:0]  prod_q;
  logic                 up_q;

  assign up  = (price_q >= ema_q);
  assign mag = up ? (price_q - ema_q) : (ema_q - price_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdBits'(mag) * ProdBits'(alpha_q[FracBits-1:0]);
      up_q   <= up;
    end
  end

  // floor on the way up, ceiling of the magnitude on the way down
  logic [ProdBits:0]    prod_rnd;
  logic [PriceBits-1:0] step;
  logic [PriceBits-1:0] ema_nxt;
  logic [PriceBits-1:0] avg;

  assign prod_rnd = {1'b0, prod_q} + (ProdBits + 1)'((1 << FracBits) - 1);
  assign step     = up_q ? prod_q[ProdBits-1:FracBits] : prod_rnd[ProdBits-1:FracBits];
  assign avg      = quo_q[PriceBits-1:0];

  always_comb begin
    if (!seeded_q) begin
      ema_nxt = avg;
    end else if (alpha_q[AlphaBits-1]) begin
      ema_nxt = price_q;
    end else if (up_q) begin
      ema_nxt = ema_q + step;
    end else begin
      ema_nxt = ema_q - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q    <= '0;
      seeded_q <= 1'b0;
    end else if (restart) begin
      ema_q    <= '0;
      seeded_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      ema_q    <= ema_nxt;
      seeded_q <= 1'b1;
    end
  end

  // output register
  logic                 out_valid_q;
  logic [PriceBits-1:0] out_sma_q;
  logic [PriceBits-1:0] out_ema_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_sma_q <= avg;
      out_ema_q <= ema_nxt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign simple_avg_o = out_sma_q;
  assign exp_avg_o    = out_ema_q;

  always_comb begin
    status_o.emit     = ({1'b0, fill_q} + (NBits + 1)'(1)) >= {1'b0, win_n};
    status_o.div_last = (div_cnt_q == DivBits'(SumBits - 1));
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/moving_average_sma_ema_unit.sv =====
// simple and exponential moving average of a stream of unsigned q16.16 prices.
// each transaction on the input carries one price; once window_length prices
// have arrived since reset or since the last write of window_length, every
// transaction yields one result carrying the truncated mean of the last
// window_length prices and an exponential average that starts from the first
// mean and then moves by alpha*(price-ema) >>> 16 per price. during warm-up
// no result is produced. one price is worked on at a time: a price that
// produces no result keeps the input stalled while it is accumulated; a price
// that produces a result passes from acceptance through the accumulate step,
// a restoring divider step for each bit of the 38-bit window sum, the multiply
// and the ema update into the result register (the ring is read at the
// accepting edge), and waits in the ema update only while an earlier result
// still sits unread in the output register. the next price is taken as soon
// as the result is in that register. the last 64 prices live in a 64 x 32
// ring memory; no clearing pass is needed after reset, as only entries
// written since the last restart ever enter the sum. configuration is a
// plain write port (index 0 window_length, index 1 ema_alpha); writing
// window_length restarts warm-up, writing ema_alpha applies from the next
// price. write configuration only while the block is idle.
`default_nettype none

module moving_average_sma_ema_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // price input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [masma_pkg::PRICE_BITS-1:0]    price_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [masma_pkg::PRICE_BITS-1:0]    simple_avg_o,
  output logic [masma_pkg::PRICE_BITS-1:0]    exp_avg_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [masma_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [masma_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  // command and status between sequencer and datapath
  masma_pkg::cmd_t    cmd;
  masma_pkg::status_t status;

  // sequencer: accepts a transaction, steps the divider, loads the result
  masma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: ring memory, running sum, divider, ema arithmetic, result register
  masma_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .price_i      (price_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .simple_avg_o (simple_avg_o),
    .exp_avg_o    (exp_avg_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/masma_checker.sv =====
`default_nettype none

`include "moving_average_sma_ema_unit_defines.svh"

module masma_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [masma_pkg::PRICE_BITS-1:0] simple_avg_o,
  input wire logic [masma_pkg::PRICE_BITS-1:0] exp_avg_o
);

  // a held result keeps its values
  `MASMA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(simple_avg_o) && $stable(exp_avg_o))

  // an accepted price keeps the block busy for at least the next cycle
  `MASMA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a fresh result only comes out of a busy cycle
  `MASMA_ASSERT_SAME(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind moving_average_sma_ema_unit masma_checker u_masma_checker (.*);

`default_nettype wire
